// ===== hw/rtl/mtu_pkg.sv =====
// Shared types and constants for the membership table update block.
`default_nettype none
package mtu_pkg;

   localparam int KEY_W  = 64;
   localparam int INC_W  = 32;
   localparam int TIME_W = 32;
   localparam int WIT_W  = 48;
   localparam int CMD_W  = 3;
   localparam int ST_W   = 2;
   localparam int RC_W   = 2;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_NOTICE  = 3'd0,
      CMD_MERGE   = 3'd1,
      CMD_SUSPECT = 3'd2,
      CMD_DELETE  = 3'd3,
      CMD_LOOKUP  = 3'd4
   } cmd_type;

   localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd0;
   localparam logic [ST_W-1:0] ST_ALIVE   = 2'd1;
   localparam logic [ST_W-1:0] ST_SUSPECT = 2'd2;
   localparam logic [ST_W-1:0] ST_DEAD    = 2'd3;

   localparam logic [RC_W-1:0] RC_OK        = 2'd0;
   localparam logic [RC_W-1:0] RC_NOT_FOUND = 2'd1;
   localparam logic [RC_W-1:0] RC_OWN       = 2'd2;
   localparam logic [RC_W-1:0] RC_FULL      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID_HIGH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID_LOW  = 1'd1;

   // Request token walking down the cell chain, carrying its answer once settled.
   typedef struct packed {
      logic              vld;
      logic              done;
      logic [CMD_W-1:0]  cmd;
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic [INC_W-1:0]  inc;
      logic [ST_W-1:0]   gst;
      logic [TIME_W-1:0] tm;
      logic [WIT_W-1:0]  wit;
      logic [RC_W-1:0]   code;
      logic [ST_W-1:0]   r_st;
      logic [INC_W-1:0]  r_inc;
      logic [TIME_W-1:0] r_seen;
   } token_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mtu_if.sv =====
// Channel interfaces for requests, responses and register writes.
`default_nettype none
interface mtu_req_if;
   logic                        valid;
   logic                        ready;
   logic [mtu_pkg::CMD_W-1:0]   cmd;
   logic [mtu_pkg::KEY_W-1:0]   key_high;
   logic [mtu_pkg::KEY_W-1:0]   key_low;
   logic [mtu_pkg::INC_W-1:0]   incarnation;
   logic [mtu_pkg::ST_W-1:0]    gossip_status;
   logic [mtu_pkg::TIME_W-1:0]  event_time;
   logic [mtu_pkg::WIT_W-1:0]   witness_addr;
   modport source (output valid, cmd, key_high, key_low, incarnation, gossip_status,
                   event_time, witness_addr, input ready);
   modport sink   (input valid, cmd, key_high, key_low, incarnation, gossip_status,
                   event_time, witness_addr, output ready);
endinterface

interface mtu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mtu_pkg::RC_W-1:0]    result_code;
   logic [mtu_pkg::ST_W-1:0]    entry_status;
   logic [mtu_pkg::INC_W-1:0]   entry_incarnation;
   logic [mtu_pkg::TIME_W-1:0]  entry_last_seen;
   modport source (output valid, result_code, entry_status, entry_incarnation,
                   entry_last_seen, input ready);
   modport sink   (input valid, result_code, entry_status, entry_incarnation,
                   entry_last_seen, output ready);
endinterface

interface mtu_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mtu_pkg::CSR_IDX_W-1:0] index;
   logic [mtu_pkg::KEY_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mtu_cell.sv =====
// One table entry: compares the passing token, updates or fills itself.
`default_nettype none
module mtu_cell (
   input  wire                clock,
   input  wire                reset,
   input  mtu_pkg::token_type tok_i,
   output mtu_pkg::token_type tok_o
);
   import mtu_pkg::*;

   logic              valid_ff, valid_in;
   logic [KEY_W-1:0]  key_high_ff, key_high_in, key_low_ff, key_low_in;
   logic [INC_W-1:0]  inc_ff, inc_in;
   logic [ST_W-1:0]   st_ff, st_in;
   logic [TIME_W-1:0] seen_ff, seen_in;
   logic [WIT_W-1:0]  wit_ff, wit_in;
   token_type         tok_ff, tok_in;
   logic              live, hit, fill;

   always_comb begin
      valid_in    = valid_ff;
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      inc_in      = inc_ff;
      st_in       = st_ff;
      seen_in     = seen_ff;
      wit_in      = wit_ff;
      tok_in      = tok_i;
      live = tok_i.vld && !tok_i.done;
      hit  = live && valid_ff && tok_i.key_high == key_high_ff && tok_i.key_low == key_low_ff;
      fill = live && !valid_ff && tok_i.cmd == CMD_MERGE;
      if (hit) begin
         case (tok_i.cmd)
            CMD_NOTICE: begin
               if (tok_i.inc > inc_ff) begin
                  inc_in  = tok_i.inc;
                  st_in   = ST_ALIVE;
                  seen_in = tok_i.tm;
               end else if (tok_i.inc == inc_ff && st_ff != ST_DEAD) begin
                  st_in   = ST_ALIVE;
                  seen_in = tok_i.tm;
               end
            end
            CMD_MERGE: begin
               if (tok_i.inc > inc_ff) begin
                  inc_in  = tok_i.inc;
                  st_in   = tok_i.gst;
                  seen_in = tok_i.tm;
               end else if (tok_i.inc == inc_ff && (st_ff == ST_ALIVE || st_ff == ST_SUSPECT)) begin
                  if (tok_i.gst > st_ff) begin
                     st_in   = tok_i.gst;
                     seen_in = tok_i.tm;
                  end else if (tok_i.gst == st_ff && seen_ff < tok_i.tm) begin
                     seen_in = tok_i.tm;
                  end
               end
            end
            CMD_SUSPECT: begin
               st_in  = ST_SUSPECT;
               wit_in = tok_i.wit;
            end
            CMD_DELETE: st_in = ST_DEAD;
            default: ;
         endcase
      end else if (fill) begin
         valid_in    = 1'b1;
         key_high_in = tok_i.key_high;
         key_low_in  = tok_i.key_low;
         inc_in      = tok_i.inc;
         st_in       = tok_i.gst;
         seen_in     = tok_i.tm;
         wit_in      = '0;
      end
      if (hit || fill) begin
         tok_in.done   = 1'b1;
         tok_in.code   = RC_OK;
         tok_in.r_st   = st_in;
         tok_in.r_inc  = inc_in;
         tok_in.r_seen = seen_in;
      end else if (live && !valid_ff) begin
         // entries fill from the front, so an empty cell ends the search
         tok_in.done = 1'b1;
         tok_in.code = RC_NOT_FOUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
      key_high_ff <= key_high_in;
      key_low_ff  <= key_low_in;
      inc_ff      <= inc_in;
      st_ff       <= st_in;
      seen_ff     <= seen_in;
      wit_ff      <= wit_in;
   end

   assign tok_o = tok_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/membership_table_update_top.sv =====
// Top level of the membership table: request intake, cell chain, response register.
// A request token is registered at intake, walks every registered cell of the chain,
// and its answer is captured in the response register.
// A new request is taken only after the previous response transfer.
// Reset empties the table (all entry valid bits clear) and zeroes the own identifier.
// Register writes are always accepted; issue them only while the block is idle.
`default_nettype none
module membership_table_update_top #(
   parameter int TABLE_DEPTH = 32
) (
   input wire         clock,
   input wire         reset,
   mtu_req_if.sink    req_bus,
   mtu_rsp_if.source  rsp_bus,
   mtu_csr_if.sink    csr_bus
);
   import mtu_pkg::*;

   logic [KEY_W-1:0]  own_high_ff, own_low_ff;
   logic              busy_ff, busy_in;
   token_type         inj_ff, inj_in;
   token_type         chain [TABLE_DEPTH+1];
   logic              rsp_vld_ff, rsp_vld_in;
   logic [RC_W-1:0]   rc_ff, rc_in;
   logic [ST_W-1:0]   st_ff, st_in;
   logic [INC_W-1:0]  inc_ff, inc_in;
   logic [TIME_W-1:0] seen_ff, seen_in;
   logic              req_xfer, rsp_xfer, own_hit;
   token_type         tail;

   assign req_bus.ready = !busy_ff;
   assign csr_bus.ready = 1'b1;
   assign req_xfer = req_bus.valid && !busy_ff;
   assign rsp_xfer = rsp_vld_ff && rsp_bus.ready;

   // own identifier: hold the two halves
   always_ff @(posedge clock) begin
      if (reset) begin
         own_high_ff <= '0;
         own_low_ff  <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_OWN_ID_HIGH: own_high_ff <= csr_bus.data;
            CSR_OWN_ID_LOW:  own_low_ff  <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // build the token; merge and delete of the own identifier settle at once
   always_comb begin
      own_hit = req_bus.key_high == own_high_ff && req_bus.key_low == own_low_ff;
      inj_in          = '0;
      inj_in.vld      = req_xfer;
      inj_in.cmd      = req_bus.cmd;
      inj_in.key_high = req_bus.key_high;
      inj_in.key_low  = req_bus.key_low;
      inj_in.inc      = req_bus.incarnation;
      inj_in.gst      = req_bus.gossip_status;
      inj_in.tm       = req_bus.event_time;
      inj_in.wit      = req_bus.witness_addr;
      if (own_hit && (req_bus.cmd == CMD_MERGE || req_bus.cmd == CMD_DELETE)) begin
         inj_in.done = 1'b1;
         inj_in.code = RC_OWN;
      end
   end

   assign chain[0] = inj_ff;

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         mtu_cell u_cell (
            .clock (clock),
            .reset (reset),
            .tok_i (chain[g]),
            .tok_o (chain[g+1])
         );
      end
   endgenerate

   assign tail = chain[TABLE_DEPTH];

   // capture the token leaving the chain; an unsettled merge means no free cell
   always_comb begin
      busy_in    = busy_ff;
      rsp_vld_in = rsp_vld_ff;
      rc_in      = rc_ff;
      st_in      = st_ff;
      inc_in     = inc_ff;
      seen_in    = seen_ff;
      if (req_xfer) busy_in = 1'b1;
      if (rsp_xfer) begin
         rsp_vld_in = 1'b0;
         busy_in    = 1'b0;
      end
      if (tail.vld) begin
         rsp_vld_in = 1'b1;
         if (tail.done) begin
            rc_in   = tail.code;
            st_in   = tail.r_st;
            inc_in  = tail.r_inc;
            seen_in = tail.r_seen;
         end else begin
            rc_in   = (tail.cmd == CMD_MERGE) ? RC_FULL : RC_NOT_FOUND;
            st_in   = '0;
            inc_in  = '0;
            seen_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
         inj_ff     <= '0;
      end else begin
         busy_ff    <= busy_in;
         rsp_vld_ff <= rsp_vld_in;
         inj_ff     <= inj_in;
      end
      rc_ff   <= rc_in;
      st_ff   <= st_in;
      inc_ff  <= inc_in;
      seen_ff <= seen_in;
   end

   assign rsp_bus.valid             = rsp_vld_ff;
   assign rsp_bus.result_code       = rc_ff;
   assign rsp_bus.entry_status      = st_ff;
   assign rsp_bus.entry_incarnation = inc_ff;
   assign rsp_bus.entry_last_seen   = seen_ff;

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> busy_ff) else $error("response without request in flight");
   a_inject: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> inj_ff.vld) else $error("accepted request not injected");
   a_tail_busy: assert property (@(posedge clock) disable iff (reset)
      tail.vld |-> busy_ff && !rsp_vld_ff) else $error("token left chain while idle");
   a_own_code: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rc_ff != RC_OK |-> st_ff == '0 && inc_ff == '0 && seen_ff == '0)
      else $error("nonzero entry fields on failed request");

endmodule
`default_nettype wire
